// ----- sv/fcfr_pkg.sv -----
`timescale 1ns / 1ps
// Package for the rotating-frame central convective flux block.
// Holds the face record, word constants and the flux microcode table.
package fcfr_pkg;

    localparam int WORD_W = 32;
    localparam int FRAC_W = 16;
    localparam int STEP_W = 6;
    localparam logic [STEP_W-1:0] LAST_STEP = 6'd37;

    typedef struct packed {
        logic [WORD_W-1:0] density;
        logic [WORD_W-1:0] vel_x;
        logic [WORD_W-1:0] vel_y;
        logic [WORD_W-1:0] vel_z;
        logic [WORD_W-1:0] pressure;
        logic [WORD_W-1:0] area_x;
        logic [WORD_W-1:0] area_y;
        logic [WORD_W-1:0] area_z;
        logic [WORD_W-1:0] face_x;
        logic [WORD_W-1:0] face_y;
    } face_t;

    typedef enum logic [1:0] {
        OP_MUL = 2'd0,
        OP_ADD = 2'd1,
        OP_SUB = 2'd2,
        OP_NEG = 2'd3
    } op_t;

    typedef enum logic [4:0] {
        RG_D    = 5'd0,
        RG_U    = 5'd1,
        RG_V    = 5'd2,
        RG_W    = 5'd3,
        RG_P    = 5'd4,
        RG_SX   = 5'd5,
        RG_SY   = 5'd6,
        RG_SZ   = 5'd7,
        RG_FX   = 5'd8,
        RG_FY   = 5'd9,
        RG_ROT  = 5'd10,
        RG_IGM  = 5'd11,
        RG_HALF = 5'd12,
        RG_T0   = 5'd13,
        RG_T1   = 5'd14,
        RG_T2   = 5'd15,
        RG_T3   = 5'd16,
        RG_T4   = 5'd17,
        RG_R0   = 5'd18,
        RG_R1   = 5'd19,
        RG_R2   = 5'd20,
        RG_R3   = 5'd21,
        RG_R4   = 5'd22
    } reg_t;

    typedef struct packed {
        op_t  op;
        reg_t dst;
        reg_t src_a;
        reg_t src_b;
    } uop_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_OUT  = 3'b100
    } back_state_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic uop_t uop_at(input logic [STEP_W-1:0] step);
        uop_t u;
        case (step)
            6'd0:    u = '{OP_MUL, RG_T0, RG_FY, RG_ROT};
            6'd1:    u = '{OP_NEG, RG_T0, RG_T0, RG_T0};
            6'd2:    u = '{OP_MUL, RG_T1, RG_FX, RG_ROT};
            6'd3:    u = '{OP_MUL, RG_T2, RG_U, RG_SX};
            6'd4:    u = '{OP_MUL, RG_T3, RG_V, RG_SY};
            6'd5:    u = '{OP_ADD, RG_T2, RG_T2, RG_T3};
            6'd6:    u = '{OP_MUL, RG_T3, RG_W, RG_SZ};
            6'd7:    u = '{OP_ADD, RG_T2, RG_T2, RG_T3};
            6'd8:    u = '{OP_MUL, RG_T0, RG_T0, RG_SX};
            6'd9:    u = '{OP_MUL, RG_T1, RG_T1, RG_SY};
            6'd10:   u = '{OP_ADD, RG_T0, RG_T0, RG_T1};
            6'd11:   u = '{OP_SUB, RG_T1, RG_T2, RG_T0};
            6'd12:   u = '{OP_MUL, RG_T2, RG_U, RG_U};
            6'd13:   u = '{OP_MUL, RG_T3, RG_V, RG_V};
            6'd14:   u = '{OP_ADD, RG_T2, RG_T2, RG_T3};
            6'd15:   u = '{OP_MUL, RG_T3, RG_W, RG_W};
            6'd16:   u = '{OP_ADD, RG_T2, RG_T2, RG_T3};
            6'd17:   u = '{OP_MUL, RG_T2, RG_D, RG_T2};
            6'd18:   u = '{OP_MUL, RG_T2, RG_T2, RG_HALF};
            6'd19:   u = '{OP_MUL, RG_T3, RG_P, RG_IGM};
            6'd20:   u = '{OP_ADD, RG_T2, RG_T3, RG_T2};
            6'd21:   u = '{OP_ADD, RG_T2, RG_T2, RG_P};
            6'd22:   u = '{OP_MUL, RG_T2, RG_T2, RG_T1};
            6'd23:   u = '{OP_MUL, RG_T3, RG_P, RG_T0};
            6'd24:   u = '{OP_ADD, RG_R4, RG_T2, RG_T3};
            6'd25:   u = '{OP_MUL, RG_R0, RG_D, RG_T1};
            6'd26:   u = '{OP_MUL, RG_T3, RG_D, RG_U};
            6'd27:   u = '{OP_MUL, RG_T3, RG_T3, RG_T1};
            6'd28:   u = '{OP_MUL, RG_T4, RG_P, RG_SX};
            6'd29:   u = '{OP_ADD, RG_R1, RG_T3, RG_T4};
            6'd30:   u = '{OP_MUL, RG_T3, RG_D, RG_V};
            6'd31:   u = '{OP_MUL, RG_T3, RG_T3, RG_T1};
            6'd32:   u = '{OP_MUL, RG_T4, RG_P, RG_SY};
            6'd33:   u = '{OP_ADD, RG_R2, RG_T3, RG_T4};
            6'd34:   u = '{OP_MUL, RG_T3, RG_D, RG_W};
            6'd35:   u = '{OP_MUL, RG_T3, RG_T3, RG_T1};
            6'd36:   u = '{OP_MUL, RG_T4, RG_P, RG_SZ};
            6'd37:   u = '{OP_ADD, RG_R3, RG_T3, RG_T4};
            default: u = '{OP_ADD, RG_T0, RG_T0, RG_T0};
        endcase
        return u;
    endfunction

endpackage

// ----- sv/fcfr_front.sv -----
`timescale 1ns / 1ps
// Front end: accepts cells, holds the previous cell and forms face averages.
// Depends on fcfr_pkg.
module fcfr_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   line_start,
    input  fcfr_pkg::face_t        cell_in,
    input  fcfr_pkg::q_status_t    q_status,
    output logic                   push,
    output fcfr_pkg::face_t        push_data
);
    import fcfr_pkg::*;

    logic              have_prev_reg;
    logic              have_prev_next;
    logic [WORD_W-1:0] prev_d_reg, prev_u_reg, prev_v_reg, prev_w_reg, prev_p_reg;
    logic              accept;

    function automatic logic [WORD_W-1:0] avg(input logic [WORD_W-1:0] a,
                                               input logic [WORD_W-1:0] b);
        logic [WORD_W:0] s;
        s = {a[WORD_W-1], a} + {b[WORD_W-1], b};
        return s[WORD_W:1];
    endfunction

    assign in_ready       = !q_status.full;
    assign accept         = in_valid && in_ready;
    assign push           = accept && !line_start && have_prev_reg;
    assign have_prev_next = have_prev_reg || accept;

    always_comb
    begin
        push_data          = cell_in;
        push_data.density  = avg(cell_in.density, prev_d_reg);
        push_data.vel_x    = avg(cell_in.vel_x, prev_u_reg);
        push_data.vel_y    = avg(cell_in.vel_y, prev_v_reg);
        push_data.vel_z    = avg(cell_in.vel_z, prev_w_reg);
        push_data.pressure = avg(cell_in.pressure, prev_p_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_prev_reg <= 1'b0;
        end
        else
        begin
            have_prev_reg <= have_prev_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            prev_d_reg <= cell_in.density;
            prev_u_reg <= cell_in.vel_x;
            prev_v_reg <= cell_in.vel_y;
            prev_w_reg <= cell_in.vel_z;
            prev_p_reg <= cell_in.pressure;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_status.full)
        else $error("face pushed into a full queue");
    a_first_cell_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && line_start) |-> !push)
        else $error("line start produced a face");
    a_prev_held: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> have_prev_reg)
        else $error("accepted cell not held");
`endif
endmodule

// ----- sv/fcfr_queue.sv -----
`timescale 1ns / 1ps
// Two-entry queue of face records between the front and back ends.
// Depends on fcfr_pkg.
module fcfr_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  fcfr_pkg::face_t     push_data,
    input  logic                pop,
    output fcfr_pkg::face_t     head,
    output fcfr_pkg::q_status_t status
);
    import fcfr_pkg::*;

    face_t      entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign head         = entry_reg[rd_ptr_reg];
    assign status.full  = count_reg == 2'd2;
    assign status.empty = count_reg == 2'd0;
    assign wr_ptr_next  = push ? !wr_ptr_reg : wr_ptr_reg;
    assign rd_ptr_next  = pop ? !rd_ptr_reg : rd_ptr_reg;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue count out of range");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !status.empty)
        else $error("pop from empty queue");
    a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd1) |-> (wr_ptr_reg != rd_ptr_reg))
        else $error("queue pointers disagree with count");
`endif
endmodule

// ----- sv/fcfr_back.sv -----
`timescale 1ns / 1ps
// Back end: evaluates the five fluxes of one face with one shared saturating
// multiplier and adder stepped by the microcode table. Depends on fcfr_pkg.
module fcfr_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  fcfr_pkg::q_status_t         q_status,
    input  fcfr_pkg::face_t             head,
    output logic                        pop,
    input  logic [30:0]                 inv_gamma_minus_one,
    input  logic [fcfr_pkg::WORD_W-1:0] rotation_speed,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [5*fcfr_pkg::WORD_W-1:0] out_data
);
    import fcfr_pkg::*;

    localparam logic [WORD_W-1:0] HALF = WORD_W'(1) << (FRAC_W - 1);
    localparam logic [2*WORD_W-FRAC_W-1:0] LIM_POS =
        (2*WORD_W-FRAC_W)'({1'b0, {(WORD_W-1){1'b1}}});
    localparam logic [2*WORD_W-FRAC_W-1:0] LIM_NEG =
        (2*WORD_W-FRAC_W)'({1'b1, {(WORD_W-1){1'b0}}});

    back_state_t       state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              phase_reg, phase_next;
    face_t             face_reg;
    logic [WORD_W-1:0] t0_reg, t1_reg, t2_reg, t3_reg, t4_reg;
    logic [WORD_W-1:0] r0_reg, r1_reg, r2_reg, r3_reg, r4_reg;
    logic [2*WORD_W-1:0] prod_reg;
    logic              neg_reg;
    logic [WORD_W+1:0] sum_reg;
    op_t               op_reg;
    reg_t              dst_reg;
    uop_t              uop;
    logic [WORD_W-1:0] opa, opb, mag_a, mag_b, result;
    logic [WORD_W+1:0] sa, sb, sum_next;
    logic [2*WORD_W-FRAC_W-1:0] shifted, lim, smag;

    function automatic logic [WORD_W-1:0] pick(input reg_t sel, input face_t f,
        input logic [WORD_W-1:0] igm, input logic [WORD_W-1:0] rot,
        input logic [WORD_W-1:0] t0, input logic [WORD_W-1:0] t1,
        input logic [WORD_W-1:0] t2, input logic [WORD_W-1:0] t3,
        input logic [WORD_W-1:0] t4);
        logic [WORD_W-1:0] v;
        case (sel)
            RG_D:    v = f.density;
            RG_U:    v = f.vel_x;
            RG_V:    v = f.vel_y;
            RG_W:    v = f.vel_z;
            RG_P:    v = f.pressure;
            RG_SX:   v = f.area_x;
            RG_SY:   v = f.area_y;
            RG_SZ:   v = f.area_z;
            RG_FX:   v = f.face_x;
            RG_FY:   v = f.face_y;
            RG_ROT:  v = rot;
            RG_IGM:  v = igm;
            RG_HALF: v = HALF;
            RG_T0:   v = t0;
            RG_T1:   v = t1;
            RG_T2:   v = t2;
            RG_T3:   v = t3;
            RG_T4:   v = t4;
            default: v = '0;
        endcase
        return v;
    endfunction

    assign uop = uop_at(step_reg);
    assign opa = pick(uop.src_a, face_reg, {1'b0, inv_gamma_minus_one}, rotation_speed,
                      t0_reg, t1_reg, t2_reg, t3_reg, t4_reg);
    assign opb = pick(uop.src_b, face_reg, {1'b0, inv_gamma_minus_one}, rotation_speed,
                      t0_reg, t1_reg, t2_reg, t3_reg, t4_reg);
    assign mag_a = opa[WORD_W-1] ? (WORD_W'(0) - opa) : opa;
    assign mag_b = opb[WORD_W-1] ? (WORD_W'(0) - opb) : opb;
    assign sa    = {{2{opa[WORD_W-1]}}, opa};
    assign sb    = {{2{opb[WORD_W-1]}}, opb};

    always_comb
    begin
        case (uop.op)
            OP_ADD:  sum_next = sa + sb;
            OP_SUB:  sum_next = sa - sb;
            OP_NEG:  sum_next = (WORD_W+2)'(0) - sa;
            default: sum_next = '0;
        endcase
    end

    assign shifted = prod_reg[2*WORD_W-1:FRAC_W];
    assign lim     = neg_reg ? LIM_NEG : LIM_POS;
    assign smag    = (shifted > lim) ? lim : shifted;

    always_comb
    begin
        if (op_reg == OP_MUL)
        begin
            result = neg_reg ? (WORD_W'(0) - smag[WORD_W-1:0]) : smag[WORD_W-1:0];
        end
        else if (sum_reg[WORD_W+1:WORD_W-1] == 3'b000 ||
                 sum_reg[WORD_W+1:WORD_W-1] == 3'b111)
        begin
            result = sum_reg[WORD_W-1:0];
        end
        else
        begin
            result = sum_reg[WORD_W+1] ? {1'b1, {(WORD_W-1){1'b0}}}
                                       : {1'b0, {(WORD_W-1){1'b1}}};
        end
    end

    assign pop       = (state_reg == ST_IDLE) && !q_status.empty;
    assign out_valid = state_reg == ST_OUT;
    assign out_data  = {r4_reg, r3_reg, r2_reg, r1_reg, r0_reg};

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        phase_next = phase_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (pop)
                begin
                    state_next = ST_RUN;
                    step_next  = '0;
                    phase_next = 1'b0;
                end
            end
            ST_RUN:
            begin
                phase_next = !phase_reg;
                if (phase_reg)
                begin
                    if (step_reg == LAST_STEP)
                    begin
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        step_next = step_reg + STEP_W'(1);
                    end
                end
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            phase_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            face_reg <= head;
        end
        if (state_reg == ST_RUN && !phase_reg)
        begin
            prod_reg <= mag_a * mag_b;
            neg_reg  <= opa[WORD_W-1] ^ opb[WORD_W-1];
            sum_reg  <= sum_next;
            op_reg   <= uop.op;
            dst_reg  <= uop.dst;
        end
        if (state_reg == ST_RUN && phase_reg)
        begin
            case (dst_reg)
                RG_T0:   t0_reg <= result;
                RG_T1:   t1_reg <= result;
                RG_T2:   t2_reg <= result;
                RG_T3:   t3_reg <= result;
                RG_T4:   t4_reg <= result;
                RG_R0:   r0_reg <= result;
                RG_R1:   r1_reg <= result;
                RG_R2:   r2_reg <= result;
                RG_R3:   r3_reg <= result;
                RG_R4:   r4_reg <= result;
                default: ;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= LAST_STEP)
        else $error("microcode step out of range");
    a_result_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(step_reg) == LAST_STEP)
        else $error("result shown before the last step");
    a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> state_reg == ST_RUN && step_reg == '0)
        else $error("face taken without starting a run");
`endif
endmodule

// ----- sv/face_convective_flux_rotating_core.sv -----
`timescale 1ns / 1ps
// A face's result is offered after its cell is accepted, pushed into the queue,
// taken by the sequencer and run through 38 steps of the shared multiplier and
// adder; it then waits in the output registers until taken. The sequencer takes
// no new face until that result is taken; the two-entry queue keeps taking cells
// meanwhile until it is full. Reset clears the held-cell flag, the queue
// and the sequencer; configuration resets to 2.5 and zero.
module face_convective_flux_rotating_core (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // density, vel_x, vel_y, vel_z, pressure, area_x, area_y, area_z,
    // face_x, face_y, 32 bits each from the lowest bit up.
    input  logic [319:0] s_tdata,
    // line_start.
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // flux_mass, flux_mom_x, flux_mom_y, flux_mom_z, flux_energy, from bit 0.
    output logic [159:0] m_tdata,
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [31:0]  cfg_data
);
    import fcfr_pkg::*;

    localparam logic CFG_IGM = 1'b0;
    localparam logic CFG_ROT = 1'b1;

    logic [30:0]       igm_reg;
    logic [WORD_W-1:0] rot_reg;
    face_t             cell_in, push_data, head;
    q_status_t         q_status;
    logic              push, pop;

    assign cell_in.density  = s_tdata[31:0];
    assign cell_in.vel_x    = s_tdata[63:32];
    assign cell_in.vel_y    = s_tdata[95:64];
    assign cell_in.vel_z    = s_tdata[127:96];
    assign cell_in.pressure = s_tdata[159:128];
    assign cell_in.area_x   = s_tdata[191:160];
    assign cell_in.area_y   = s_tdata[223:192];
    assign cell_in.area_z   = s_tdata[255:224];
    assign cell_in.face_x   = s_tdata[287:256];
    assign cell_in.face_y   = s_tdata[319:288];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            igm_reg <= 31'd163840;
            rot_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_IGM: igm_reg <= cfg_data[30:0];
                CFG_ROT: rot_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    fcfr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .line_start (s_tuser),
        .cell_in    (cell_in),
        .q_status   (q_status),
        .push       (push),
        .push_data  (push_data)
    );

    fcfr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .status    (q_status)
    );

    fcfr_back u_back (
        .clk                 (clk),
        .rst_n               (rst_n),
        .q_status            (q_status),
        .head                (head),
        .pop                 (pop),
        .inv_gamma_minus_one (igm_reg),
        .rotation_speed      (rot_reg),
        .out_valid           (m_tvalid),
        .out_ready           (m_tready),
        .out_data            (m_tdata)
    );
endmodule
